[rtl/core/assert_macros.svh]
// assertion macros used by the rssi gate crossing detector
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/core/rgcd_pkg.sv]
// types and constants of the rssi gate crossing detector
package rgcd_pkg;

    localparam logic [7:0]  RSSI_MAX     = 8'hFF;
    localparam logic [15:0] DURATION_MAX = 16'hFFFF;

    // input kinds
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_RESET  = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    // result kinds
    localparam logic [1:0] RES_PEAK   = 2'd0;
    localparam logic [1:0] RES_NADIR  = 2'd1;
    localparam logic [1:0] RES_PASS   = 2'd2;
    localparam logic [1:0] RES_STATUS = 2'd3;

    // direction of the last level change
    localparam logic [1:0] SIGN_FLAT = 2'b00;
    localparam logic [1:0] SIGN_UP   = 2'b01;
    localparam logic [1:0] SIGN_DOWN = 2'b11;

    // configuration register indexes
    localparam logic [1:0] REG_ACTIVATED   = 2'd0;
    localparam logic [1:0] REG_ENTER_LEVEL = 2'd1;
    localparam logic [1:0] REG_EXIT_LEVEL  = 2'd2;

    localparam logic [7:0] ENTER_RESET = 8'd96;
    localparam logic [7:0] EXIT_RESET  = 8'd80;

    localparam int RES_DEPTH = 4;

    typedef struct packed {
        logic [7:0]  level;
        logic [31:0] first_ms;
        logic [15:0] dur;
    } ext_t;

    typedef struct packed {
        logic [1:0]  kind_res;
        logic [7:0]  level;
        logic [31:0] first_time;
        logic [15:0] duration;
        logic [7:0]  pass_nadir;
        logic [7:0]  lap_count;
        logic        crossing;
        logic [7:0]  lifetime_peak;
        logic [7:0]  lifetime_nadir;
        logic        last;
    } res_t;

endpackage

[rtl/core/rssi_gate_crossing_detector.sv]
// rssi gate crossing detector: extremum tracking, lifetime range and pass reports
// Each input item (sample, tracking reset or end-crossing command) waits in the input register
// until the result buffer is free, is then processed against the tracking state, and loads one to
// four result items into a four-entry result buffer; the last of them is the status item,
// marked by m_tlast. Results leave one per cycle on the single result channel while m_tready is
// high, and an item is processed only once all results of the previous item have left; the input
// register can meanwhile take the next item. A new item is loaded in the cycle the previous item's
// final result leaves. Configuration writes take effect on the next processed item.
`include "assert_macros.svh"

module rssi_gate_crossing_detector (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // rssi, timestamp, peak_slot_free, nadir_slot_free
    input  logic [1:0]  s_tuser,   // kind
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // level, first_time, duration, pass_nadir, lap_count, crossing,
    // lifetime_peak, lifetime_nadir
    output logic [95:0] m_tdata,
    output logic [1:0]  m_tuser,   // kind_res
    output logic        m_tlast    // last
);

    // configuration
    logic       activated_reg;
    logic [7:0] enter_level_reg;
    logic [7:0] exit_level_reg;

    // input register
    logic        in_valid_reg;
    logic [1:0]  in_kind_reg;
    logic [7:0]  in_rssi_reg;
    logic [31:0] in_ts_reg;
    logic        in_pfree_reg;
    logic        in_nfree_reg;

    // tracking state
    logic [7:0]          cur_reg, cur_next;
    logic [1:0]          sign_reg, sign_next;
    rgcd_pkg::ext_t      hp_reg, hp_next;
    rgcd_pkg::ext_t      hn_reg, hn_next;
    rgcd_pkg::ext_t      pp_reg, pp_next;
    logic                peak_pend_reg, peak_pend_next;
    logic                nadir_pend_reg, nadir_pend_next;
    logic [7:0]          life_max_reg, life_max_next;
    logic [7:0]          life_min_reg, life_min_next;
    logic                in_cross_reg, in_cross_next;
    logic [7:0]          pass_low_reg, pass_low_next;
    logic [7:0]          laps_reg, laps_next;

    // result buffer
    rgcd_pkg::res_t res_reg [rgcd_pkg::RES_DEPTH];
    rgcd_pkg::res_t res_next [rgcd_pkg::RES_DEPTH];
    logic [2:0]     res_cnt_next;
    logic [2:0]     res_left_reg;
    logic [1:0]     rd_ptr_reg;

    logic           buf_free;
    logic           load;
    logic           pop;
    rgcd_pkg::res_t out_res;
    rgcd_pkg::res_t pass_rec;

    logic [31:0] hp_diff, hn_diff, pp_diff;
    logic [15:0] hp_dur, hn_dur, pp_dur;
    logic        rising, falling, do_end;

    function automatic logic [15:0] sat_dur(input logic [31:0] diff);
        sat_dur = (diff > {16'd0, rgcd_pkg::DURATION_MAX}) ? rgcd_pkg::DURATION_MAX
                                                          : diff[15:0];
    endfunction

    function automatic rgcd_pkg::res_t ext_res(input logic [1:0] kind,
                                               input rgcd_pkg::ext_t e);
        rgcd_pkg::res_t r;
        r            = '0;
        r.kind_res   = kind;
        r.level      = e.level;
        r.first_time = e.first_ms;
        r.duration   = e.dur;
        ext_res      = r;
    endfunction

    // handshake
    assign pop      = m_tvalid && m_tready;
    assign buf_free = (res_left_reg == 3'd0) || (pop && res_left_reg == 3'd1);
    assign load     = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || load;

    assign out_res  = res_reg[rd_ptr_reg];
    assign m_tvalid = (res_left_reg != 3'd0);
    assign m_tuser  = out_res.kind_res;
    assign m_tlast  = out_res.last;
    assign m_tdata  = {7'd0, out_res.lifetime_nadir, out_res.lifetime_peak, out_res.crossing,
                       out_res.lap_count, out_res.pass_nadir, out_res.duration,
                       out_res.first_time, out_res.level};

    // flat durations, all from the stored first times
    assign hp_diff = in_ts_reg - hp_reg.first_ms;
    assign hn_diff = in_ts_reg - hn_reg.first_ms;
    assign pp_diff = in_ts_reg - pp_reg.first_ms;
    assign hp_dur  = sat_dur(hp_diff);
    assign hn_dur  = sat_dur(hn_diff);
    assign pp_dur  = sat_dur(pp_diff);

    assign rising  = in_rssi_reg > cur_reg;
    assign falling = in_rssi_reg < cur_reg;

    // pass report, midpoint of the peak plateau
    always_comb begin
        pass_rec            = '0;
        pass_rec.kind_res   = rgcd_pkg::RES_PASS;
        pass_rec.level      = pp_reg.level;
        pass_rec.first_time = pp_reg.first_ms + {17'd0, pp_reg.dur[15:1]};
        pass_rec.pass_nadir = pass_low_reg;
        pass_rec.lap_count  = laps_reg + 8'd1;
    end

    always_comb begin
        cur_next        = cur_reg;
        sign_next       = sign_reg;
        hp_next         = hp_reg;
        hn_next         = hn_reg;
        pp_next         = pp_reg;
        peak_pend_next  = peak_pend_reg;
        nadir_pend_next = nadir_pend_reg;
        life_max_next   = life_max_reg;
        life_min_next   = life_min_reg;
        in_cross_next   = in_cross_reg;
        pass_low_next   = pass_low_reg;
        laps_next       = laps_reg;
        do_end          = 1'b0;
        res_cnt_next    = 3'd0;
        for (int i = 0; i < rgcd_pkg::RES_DEPTH; i++) begin
            res_next[i] = '0;
        end

        case (in_kind_reg)
            rgcd_pkg::KIND_SAMPLE: begin
                if (activated_reg) begin
                    cur_next = in_rssi_reg;
                    if (rising) begin
                        if (peak_pend_next) begin
                            res_next[res_cnt_next[1:0]] = ext_res(rgcd_pkg::RES_PEAK, hp_next);
                            res_cnt_next   = res_cnt_next + 3'd1;
                            peak_pend_next = 1'b0;
                        end
                        hp_next = '{in_rssi_reg, in_ts_reg, 16'd0};
                        if (sign_reg != rgcd_pkg::SIGN_UP) begin
                            nadir_pend_next = 1'b1;
                        end
                    end else if (falling) begin
                        if (nadir_pend_next) begin
                            res_next[res_cnt_next[1:0]] = ext_res(rgcd_pkg::RES_NADIR, hn_next);
                            res_cnt_next    = res_cnt_next + 3'd1;
                            nadir_pend_next = 1'b0;
                        end
                        hn_next = '{in_rssi_reg, in_ts_reg, 16'd0};
                        if (sign_reg != rgcd_pkg::SIGN_DOWN) begin
                            peak_pend_next = 1'b1;
                        end
                    end else if (in_rssi_reg == hp_reg.level) begin
                        hp_next.dur = hp_dur;
                        // plateau saturated: flush and restart the peak
                        if (hp_dur == rgcd_pkg::DURATION_MAX) begin
                            if (peak_pend_next) begin
                                res_next[res_cnt_next[1:0]] = ext_res(rgcd_pkg::RES_PEAK,
                                                                      hp_next);
                                res_cnt_next   = res_cnt_next + 3'd1;
                                peak_pend_next = 1'b0;
                            end
                            hp_next = '{in_rssi_reg, in_ts_reg, 16'd0};
                        end
                    end else if (in_rssi_reg == hn_reg.level) begin
                        hn_next.dur = hn_dur;
                        if (hn_dur == rgcd_pkg::DURATION_MAX) begin
                            if (nadir_pend_next) begin
                                res_next[res_cnt_next[1:0]] = ext_res(rgcd_pkg::RES_NADIR,
                                                                      hn_next);
                                res_cnt_next    = res_cnt_next + 3'd1;
                                nadir_pend_next = 1'b0;
                            end
                            hn_next = '{in_rssi_reg, in_ts_reg, 16'd0};
                        end
                    end
                    sign_next = rising ? rgcd_pkg::SIGN_UP
                              : (falling ? rgcd_pkg::SIGN_DOWN : rgcd_pkg::SIGN_FLAT);

                    // slot-driven flush
                    if (peak_pend_next && in_pfree_reg) begin
                        res_next[res_cnt_next[1:0]] = ext_res(rgcd_pkg::RES_PEAK, hp_next);
                        res_cnt_next   = res_cnt_next + 3'd1;
                        peak_pend_next = 1'b0;
                    end
                    if (nadir_pend_next && in_nfree_reg) begin
                        res_next[res_cnt_next[1:0]] = ext_res(rgcd_pkg::RES_NADIR, hn_next);
                        res_cnt_next    = res_cnt_next + 3'd1;
                        nadir_pend_next = 1'b0;
                    end

                    if (in_rssi_reg > life_max_reg) begin
                        life_max_next = in_rssi_reg;
                    end
                    if (in_rssi_reg < life_min_reg) begin
                        life_min_next = in_rssi_reg;
                    end

                    if (!in_cross_reg && in_rssi_reg >= enter_level_reg) begin
                        in_cross_next = 1'b1;
                    end else if (in_cross_reg && in_rssi_reg < exit_level_reg) begin
                        do_end = 1'b1;
                    end
                end
            end
            rgcd_pkg::KIND_RESET: begin
                in_cross_next   = 1'b0;
                pp_next         = '0;
                pass_low_next   = rgcd_pkg::RSSI_MAX;
                life_max_next   = 8'd0;
                life_min_next   = rgcd_pkg::RSSI_MAX;
                hp_next         = '0;
                peak_pend_next  = 1'b0;
                hn_next         = '{rgcd_pkg::RSSI_MAX, 32'd0, 16'd0};
                nadir_pend_next = 1'b0;
            end
            rgcd_pkg::KIND_END: begin
                do_end = 1'b1;
            end
            default: begin
            end
        endcase

        if (do_end) begin
            res_next[res_cnt_next[1:0]] = pass_rec;
            res_cnt_next  = res_cnt_next + 3'd1;
            laps_next     = pass_rec.lap_count;
            in_cross_next = 1'b0;
            pp_next.level = 8'd0;
            pass_low_next = rgcd_pkg::RSSI_MAX;
        end

        // pass peak and pass low follow the sample after the crossing decision
        if (in_kind_reg == rgcd_pkg::KIND_SAMPLE && activated_reg) begin
            if (in_cross_next) begin
                if (in_rssi_reg > pp_reg.level) begin
                    pp_next = '{in_rssi_reg, in_ts_reg, 16'd0};
                end else if (in_rssi_reg == pp_reg.level) begin
                    pp_next.dur = pp_dur;
                end
            end else if (in_rssi_reg < pass_low_next) begin
                pass_low_next = in_rssi_reg;
            end
        end

        res_next[res_cnt_next[1:0]].kind_res       = rgcd_pkg::RES_STATUS;
        res_next[res_cnt_next[1:0]].crossing       = in_cross_next;
        res_next[res_cnt_next[1:0]].lifetime_peak  = life_max_next;
        res_next[res_cnt_next[1:0]].lifetime_nadir = life_min_next;
        res_next[res_cnt_next[1:0]].last           = 1'b1;
        res_cnt_next = res_cnt_next + 3'd1;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            activated_reg   <= 1'b0;
            enter_level_reg <= rgcd_pkg::ENTER_RESET;
            exit_level_reg  <= rgcd_pkg::EXIT_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                rgcd_pkg::REG_ACTIVATED:   activated_reg   <= cfg_wdata[0];
                rgcd_pkg::REG_ENTER_LEVEL: enter_level_reg <= cfg_wdata;
                rgcd_pkg::REG_EXIT_LEVEL:  exit_level_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (load) begin
            in_valid_reg <= 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_kind_reg  <= s_tuser;
            in_rssi_reg  <= s_tdata[7:0];
            in_ts_reg    <= s_tdata[39:8];
            in_pfree_reg <= s_tdata[40];
            in_nfree_reg <= s_tdata[41];
        end
    end

    // tracking state, updated as the item is processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg        <= 8'd0;
            sign_reg       <= rgcd_pkg::SIGN_FLAT;
            hp_reg         <= '0;
            hn_reg         <= '{rgcd_pkg::RSSI_MAX, 32'd0, 16'd0};
            pp_reg         <= '0;
            peak_pend_reg  <= 1'b0;
            nadir_pend_reg <= 1'b0;
            life_max_reg   <= 8'd0;
            life_min_reg   <= rgcd_pkg::RSSI_MAX;
            in_cross_reg   <= 1'b0;
            pass_low_reg   <= rgcd_pkg::RSSI_MAX;
            laps_reg       <= 8'd0;
        end else if (load) begin
            cur_reg        <= cur_next;
            sign_reg       <= sign_next;
            hp_reg         <= hp_next;
            hn_reg         <= hn_next;
            pp_reg         <= pp_next;
            peak_pend_reg  <= peak_pend_next;
            nadir_pend_reg <= nadir_pend_next;
            life_max_reg   <= life_max_next;
            life_min_reg   <= life_min_next;
            in_cross_reg   <= in_cross_next;
            pass_low_reg   <= pass_low_next;
            laps_reg       <= laps_next;
        end
    end

    // result buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_left_reg <= 3'd0;
            rd_ptr_reg   <= 2'd0;
        end else if (load) begin
            res_left_reg <= res_cnt_next;
            rd_ptr_reg   <= 2'd0;
        end else if (pop) begin
            res_left_reg <= res_left_reg - 3'd1;
            rd_ptr_reg   <= rd_ptr_reg + 2'd1;
        end
        if (load) begin
            for (int i = 0; i < rgcd_pkg::RES_DEPTH; i++) begin
                res_reg[i] <= res_next[i];
            end
        end
    end

    `ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result item valid after reset")
    `ASSERT_CLK(a_left_bound, res_left_reg <= 3'd4, "result count above buffer depth")
    `ASSERT_CLK(a_last_is_final, m_tvalid |-> (m_tlast == (res_left_reg == 3'd1)),
                "last flag not on the final result item")
    `ASSERT_CLK(a_load_shows, load |=> m_tvalid, "processed item produced no result")
    `ASSERT_CLK(a_hold_input, in_valid_reg && !buf_free |=> in_valid_reg,
                "waiting input item dropped")

endmodule

[sim/rssi_gate_crossing_detector_test.sv]
// self-checking testbench for the rssi gate crossing detector
`timescale 1ns / 1ps

module rssi_gate_crossing_detector_test;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES = 6;
    localparam int ITEMS_PER_PHASE = 36;

    typedef struct {
        bit          is_write;
        logic [1:0]  reg_index;
        logic [7:0]  reg_value;
        logic [1:0]  kind;
        logic [7:0]  rssi;
        logic [31:0] ts;
        bit          pf;
        bit          nf;
        bit          typed;       // status written out below replaces the predicted one
        bit          st_crossing;
        logic [7:0]  st_peak;
        logic [7:0]  st_nadir;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // rssi, timestamp, peak_slot_free, nadir_slot_free
    logic [1:0]  s_tuser;   // kind
    logic        m_tvalid;
    logic        m_tready;
    // level, first_time, duration, pass_nadir, lap_count, crossing,
    // lifetime_peak, lifetime_nadir
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;   // kind_res
    logic        m_tlast;

    int send_idle_pct;
    int stall_pct;
    bit hold_off_req;
    int error_count;
    int cycle_count;

    // predictor state
    logic           en_reg;
    logic [7:0]     enter_reg;
    logic [7:0]     exit_reg;
    logic [7:0]     level_now;
    logic [1:0]     slope;
    rgcd_pkg::ext_t peak_hold;
    rgcd_pkg::ext_t nadir_hold;
    rgcd_pkg::ext_t pass_best;
    logic           peak_waiting;
    logic           nadir_waiting;
    logic           crossing_now;
    logic [7:0]     life_hi;
    logic [7:0]     life_lo;
    logic [7:0]     pass_floor;
    logic [7:0]     lap_total;
    rgcd_pkg::res_t expected_results[$];

    rssi_gate_crossing_detector i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic logic [15:0] flat_ms(logic [31:0] now_ms, logic [31:0] first_ms);
        logic [31:0] d;
        d = now_ms - first_ms;
        return (d > 32'(rgcd_pkg::DURATION_MAX)) ? rgcd_pkg::DURATION_MAX : d[15:0];
    endfunction

    task automatic flush_peak(input bit forced, input bit slot);
        rgcd_pkg::res_t r;
        if (peak_waiting && (slot || forced)) begin
            r = '0;
            r.kind_res = rgcd_pkg::RES_PEAK;
            r.level = peak_hold.level;
            r.first_time = peak_hold.first_ms;
            r.duration = peak_hold.dur;
            expected_results.push_back(r);
            peak_waiting = 1'b0;
        end
    endtask

    task automatic flush_nadir(input bit forced, input bit slot);
        rgcd_pkg::res_t r;
        if (nadir_waiting && (slot || forced)) begin
            r = '0;
            r.kind_res = rgcd_pkg::RES_NADIR;
            r.level = nadir_hold.level;
            r.first_time = nadir_hold.first_ms;
            r.duration = nadir_hold.dur;
            expected_results.push_back(r);
            nadir_waiting = 1'b0;
        end
    endtask

    task automatic close_pass();
        rgcd_pkg::res_t r;
        r = '0;
        lap_total = lap_total + 8'd1;
        r.kind_res = rgcd_pkg::RES_PASS;
        r.level = pass_best.level;
        // timestamp in the middle of the peak plateau, wrapping
        r.first_time = pass_best.first_ms + 32'(pass_best.dur >> 1);
        r.pass_nadir = pass_floor;
        r.lap_count = lap_total;
        expected_results.push_back(r);
        crossing_now = 1'b0;
        pass_best.level = '0;
        pass_floor = rgcd_pkg::RSSI_MAX;
    endtask

    task automatic clear_tracking();
        crossing_now = 1'b0;
        pass_best = '0;
        pass_floor = rgcd_pkg::RSSI_MAX;
        life_hi = '0;
        life_lo = rgcd_pkg::RSSI_MAX;
        peak_hold = '0;
        peak_waiting = 1'b0;
        nadir_hold = '{rgcd_pkg::RSSI_MAX, 32'd0, 16'd0};
        nadir_waiting = 1'b0;
    endtask

    task automatic track_sample(input logic [7:0] lvl, input logic [31:0] ts,
                                input bit pf, input bit nf);
        logic [7:0] prev;
        logic [1:0] dir;
        prev = level_now;
        level_now = lvl;
        dir = (lvl > prev) ? rgcd_pkg::SIGN_UP
            : ((lvl < prev) ? rgcd_pkg::SIGN_DOWN : rgcd_pkg::SIGN_FLAT);
        if (dir == rgcd_pkg::SIGN_UP) begin
            flush_peak(1'b1, pf);
            peak_hold = '{lvl, ts, 16'd0};
            if (slope != rgcd_pkg::SIGN_UP) nadir_waiting = 1'b1;
        end else if (dir == rgcd_pkg::SIGN_DOWN) begin
            flush_nadir(1'b1, nf);
            nadir_hold = '{lvl, ts, 16'd0};
            if (slope != rgcd_pkg::SIGN_DOWN) peak_waiting = 1'b1;
        end else if (lvl == peak_hold.level) begin
            peak_hold.dur = flat_ms(ts, peak_hold.first_ms);
            if (peak_hold.dur == rgcd_pkg::DURATION_MAX) begin
                flush_peak(1'b1, pf);
                peak_hold = '{lvl, ts, 16'd0};
            end
        end else if (lvl == nadir_hold.level) begin
            nadir_hold.dur = flat_ms(ts, nadir_hold.first_ms);
            if (nadir_hold.dur == rgcd_pkg::DURATION_MAX) begin
                flush_nadir(1'b1, nf);
                nadir_hold = '{lvl, ts, 16'd0};
            end
        end
        slope = dir;
        flush_peak(1'b0, pf);
        flush_nadir(1'b0, nf);
        if (lvl > life_hi) life_hi = lvl;
        if (lvl < life_lo) life_lo = lvl;
        if (!crossing_now && lvl >= enter_reg)
            crossing_now = 1'b1;
        else if (crossing_now && lvl < exit_reg)
            close_pass();
        if (crossing_now) begin
            if (lvl > pass_best.level)
                pass_best = '{lvl, ts, 16'd0};
            else if (lvl == pass_best.level)
                pass_best.dur = flat_ms(ts, pass_best.first_ms);
        end else if (lvl < pass_floor) begin
            pass_floor = lvl;
        end
    endtask

    task automatic predict_results(input logic [1:0] kind, input logic [7:0] lvl,
                                   input logic [31:0] ts, input bit pf, input bit nf);
        rgcd_pkg::res_t r;
        case (kind)
            rgcd_pkg::KIND_SAMPLE: begin
                if (en_reg) track_sample(lvl, ts, pf, nf);
            end
            rgcd_pkg::KIND_RESET: clear_tracking();
            rgcd_pkg::KIND_END: close_pass();
            default: ;
        endcase
        r = '0;
        r.kind_res = rgcd_pkg::RES_STATUS;
        r.crossing = crossing_now;
        r.lifetime_peak = life_hi;
        r.lifetime_nadir = life_lo;
        r.last = 1'b1;
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(name, got, want);
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(negedge aclk);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic [1:0] kind, input logic [7:0] lvl,
                             input logic [31:0] ts, input bit pf, input bit nf);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, nf, pf, ts, lvl};
        s_tuser <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_results(kind, lvl, ts, pf, nf);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            rgcd_pkg::REG_ACTIVATED: en_reg = val[0];
            rgcd_pkg::REG_ENTER_LEVEL: enter_reg = val;
            rgcd_pkg::REG_EXIT_LEVEL: exit_reg = val;
            default: ;
        endcase
    endtask

    function automatic stim_row_t item_row(logic [1:0] kind, logic [7:0] lvl,
                                           logic [31:0] ts, bit pf, bit nf,
                                           bit typed = 1'b0, bit cr = 1'b0,
                                           logic [7:0] hi = 8'd0, logic [7:0] lo = 8'd0);
        stim_row_t row;
        row = '{1'b0, 2'd0, 8'd0, kind, lvl, ts, pf, nf, typed, cr, hi, lo};
        return row;
    endfunction

    function automatic stim_row_t reg_row(logic [1:0] idx, logic [7:0] val);
        stim_row_t row;
        row = '{1'b1, idx, val, rgcd_pkg::KIND_SAMPLE, 8'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0,
                8'd0, 8'd0};
        return row;
    endfunction

    // receiver side: random stalls plus a long hold-off on request
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        rgcd_pkg::res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result item with nothing expected, kind", 32'(m_tuser),
                                32'd0);
            end else begin
                want = expected_results.pop_front();
                check_field("kind_res", 32'(m_tuser), 32'(want.kind_res));
                check_field("level", 32'(m_tdata[7:0]), 32'(want.level));
                check_field("first_time", m_tdata[39:8], want.first_time);
                check_field("duration", 32'(m_tdata[55:40]), 32'(want.duration));
                check_field("pass_nadir", 32'(m_tdata[63:56]), 32'(want.pass_nadir));
                check_field("lap_count", 32'(m_tdata[71:64]), 32'(want.lap_count));
                check_field("crossing", 32'(m_tdata[72]), 32'(want.crossing));
                check_field("lifetime_peak", 32'(m_tdata[80:73]), 32'(want.lifetime_peak));
                check_field("lifetime_nadir", 32'(m_tdata[88:81]), 32'(want.lifetime_nadir));
                check_field("last", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("rssi_gate_crossing_detector_test: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        stim_row_t directed[$];
        stim_row_t row;
        rgcd_pkg::res_t golden;
        int phase;
        int n;
        int r;
        int walk_level;
        logic [31:0] walk_ts;
        logic [1:0] kind;
        logic [7:0] enter_val;

        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        hold_off_req = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        error_count = 0;
        cycle_count = 0;

        en_reg = 1'b0;
        enter_reg = rgcd_pkg::ENTER_RESET;
        exit_reg = rgcd_pkg::EXIT_RESET;
        level_now = '0;
        slope = rgcd_pkg::SIGN_FLAT;
        lap_total = '0;
        clear_tracking();

        // inactive samples and the unused kind leave the reset state alone
        directed.push_back(item_row(rgcd_pkg::KIND_SAMPLE, 8'd255, 32'hFFFF_FFFF, 1, 1, 1, 0,
                                    8'd0, 8'd255));
        directed.push_back(item_row(KIND_UNUSED, 8'd0, 32'd0, 0, 0, 1, 0, 8'd0, 8'd255));
        // end command with no crossing still reports a pass
        directed.push_back(item_row(rgcd_pkg::KIND_END, 8'd0, 32'd0, 0, 0));
        directed.push_back(reg_row(rgcd_pkg::REG_ACTIVATED, 8'd1));
        directed.push_back(item_row(rgcd_pkg::KIND_SAMPLE, 8'd0, 32'd0, 1, 1, 1, 0,
                                    8'd0, 8'd0));
        directed.push_back(item_row(rgcd_pkg::KIND_SAMPLE, 8'd255, 32'd10, 0, 0));
        directed.push_back(item_row(rgcd_pkg::KIND_SAMPLE, 8'd255, 32'd20, 0, 0));
        // flat peak long enough to saturate its duration
        directed.push_back(item_row(rgcd_pkg::KIND_SAMPLE, 8'd255, 32'd70010, 0, 0));
        // forced nadir, slot-free peak, pass report and status in one item
        directed.push_back(item_row(rgcd_pkg::KIND_SAMPLE, 8'd10, 32'd70020, 1, 0));
        directed.push_back(item_row(rgcd_pkg::KIND_SAMPLE, 8'd10, 32'd70030, 0, 0));
        directed.push_back(item_row(rgcd_pkg::KIND_SAMPLE, 8'd10, 32'd0, 0, 1));
        directed.push_back(item_row(rgcd_pkg::KIND_SAMPLE, 8'd200, 32'hFFFF_FFF0, 0, 0));
        directed.push_back(item_row(rgcd_pkg::KIND_SAMPLE, 8'd200, 32'h0000_0010, 0, 0));
        // pass timestamp wraps past zero
        directed.push_back(item_row(rgcd_pkg::KIND_END, 8'd0, 32'd0, 1, 1));
        directed.push_back(item_row(rgcd_pkg::KIND_RESET, 8'd0, 32'd0, 0, 0, 1, 0,
                                    8'd0, 8'd255));
        directed.push_back(item_row(rgcd_pkg::KIND_SAMPLE, 8'd200, 32'h20, 0, 0));
        directed.push_back(item_row(rgcd_pkg::KIND_SAMPLE, 8'd100, 32'h30, 1, 1));
        directed.push_back(item_row(rgcd_pkg::KIND_SAMPLE, 8'd150, 32'h40, 0, 1));
        directed.push_back(reg_row(rgcd_pkg::REG_ENTER_LEVEL, 8'd0));
        directed.push_back(reg_row(rgcd_pkg::REG_EXIT_LEVEL, 8'd255));
        directed.push_back(item_row(rgcd_pkg::KIND_SAMPLE, 8'd0, 32'h50, 1, 1));
        directed.push_back(item_row(rgcd_pkg::KIND_SAMPLE, 8'd0, 32'h60, 1, 1));
        directed.push_back(reg_row(rgcd_pkg::REG_ENTER_LEVEL, 8'd255));
        directed.push_back(reg_row(rgcd_pkg::REG_EXIT_LEVEL, 8'd0));
        directed.push_back(item_row(rgcd_pkg::KIND_SAMPLE, 8'd254, 32'h70, 0, 0));
        directed.push_back(item_row(rgcd_pkg::KIND_END, 8'd0, 32'd0, 0, 0));
        directed.push_back(item_row(rgcd_pkg::KIND_SAMPLE, 8'd255, 32'h80, 1, 1));
        directed.push_back(item_row(KIND_UNUSED, 8'd7, 32'h5, 1, 1));
        directed.push_back(reg_row(rgcd_pkg::REG_ACTIVATED, 8'd0));
        directed.push_back(item_row(rgcd_pkg::KIND_SAMPLE, 8'd0, 32'h90, 1, 1));
        directed.push_back(reg_row(rgcd_pkg::REG_ACTIVATED, 8'd1));

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed[i]) begin
            row = directed[i];
            if (row.is_write) begin
                write_reg(row.reg_index, row.reg_value);
            end else begin
                send_item(row.kind, row.rssi, row.ts, row.pf, row.nf);
                if (row.typed) begin
                    golden = '0;
                    golden.kind_res = rgcd_pkg::RES_STATUS;
                    golden.crossing = row.st_crossing;
                    golden.lifetime_peak = row.st_peak;
                    golden.lifetime_nadir = row.st_nadir;
                    golden.last = 1'b1;
                    expected_results[expected_results.size() - 1] = golden;
                end
            end
        end

        walk_level = 128;
        walk_ts = $urandom;
        for (phase = 0; phase < 4; phase++) begin
            enter_val = 8'($urandom_range(40, 220));
            write_reg(rgcd_pkg::REG_ENTER_LEVEL, enter_val);
            // last phase may invert the hysteresis
            write_reg(rgcd_pkg::REG_EXIT_LEVEL, (phase == 3) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, enter_val)));
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 79; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 79; end
                default: begin send_idle_pct = 35; stall_pct = 35; end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 0 && n == 5) hold_off_req = 1'b1;
                if (phase == 0 && n == 25) begin
                    s_tvalid <= 1'b0;
                    wait_drained();
                end
                r = $urandom_range(0, 99);
                if (r < 3) kind = rgcd_pkg::KIND_RESET;
                else if (r < 7) kind = rgcd_pkg::KIND_END;
                else if (r < 9) kind = KIND_UNUSED;
                else kind = rgcd_pkg::KIND_SAMPLE;
                // level walk with plateaus, steps and occasional jumps
                r = $urandom_range(0, 99);
                if (r < 30) walk_level = walk_level;
                else if (r < 60) walk_level = walk_level + $urandom_range(1, 25);
                else if (r < 85) walk_level = walk_level - $urandom_range(1, 25);
                else if (r < 93) walk_level = $urandom_range(0, 255);
                else walk_level = (r % 2 != 0) ? 0 : 255;
                if (walk_level < 0) walk_level = 0;
                if (walk_level > 255) walk_level = 255;
                r = $urandom_range(0, 99);
                if (r < 5) walk_ts = walk_ts + $urandom_range(65536, 200000);
                else if (r < 7) walk_ts = $urandom;
                else walk_ts = walk_ts + $urandom_range(0, 300);
                send_item(kind, 8'(walk_level), walk_ts, $urandom_range(0, 1) != 0,
                          $urandom_range(0, 1) != 0);
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES * 2) @(negedge aclk);
        if (error_count == 0) begin
            $display("rssi_gate_crossing_detector_test: PASS");
        end else begin
            $display("rssi_gate_crossing_detector_test: FAIL");
        end
        $finish;
    end

endmodule

[rssi_gate_crossing_detector.f]
+incdir+rtl/core
rtl/core/rgcd_pkg.sv
rtl/core/rssi_gate_crossing_detector.sv
sim/rssi_gate_crossing_detector_test.sv
